### sv/hrht_pkg.sv
// ----------------------------------------------------------------------------
// hrht_pkg
// Types and constants for the HTTP response header tokenizer.
// ----------------------------------------------------------------------------
package hrht_pkg;

    // Parse phases, one-hot
    typedef enum logic [6:0] {
        PH_PROTO  = 7'b000_0001,
        PH_STATUS = 7'b000_0010,
        PH_MSG    = 7'b000_0100,
        PH_KEY    = 7'b000_1000,
        PH_VAL    = 7'b001_0000,
        PH_BODY   = 7'b010_0000,
        PH_DONE   = 7'b100_0000
    } phase_t;

    // Token classes
    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_PROTO  = 3'd1;
    localparam logic [2:0] CLS_STATUS = 3'd2;
    localparam logic [2:0] CLS_MSG    = 3'd3;
    localparam logic [2:0] CLS_KEY    = 3'd4;
    localparam logic [2:0] CLS_VAL    = 3'd5;
    localparam logic [2:0] CLS_BODY   = 3'd6;

    // Opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] KEY_LEN = 4'd14;

    // "Content-Length", one character per match position
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### sv/http_response_header_tokenizer.sv
// ----------------------------------------------------------------------------
// http_response_header_tokenizer
// Tags each byte of an HTTP response and extracts Content-Length.
// ----------------------------------------------------------------------------
// One request is one byte (or a start-of-response opcode) and yields exactly
// one result. The block sustains one request per clock unless out_stall holds
// the output register: a request is registered in the input register, then the
// parse state and the result register are updated from it once the output
// register is free. The state update (key match, decimal accumulate and body
// count compare, the last two LENGTH_BITS wide) is combinational and sets the
// rate. in_stall only rises while a request waits in the input register and
// the output register is full and held by out_stall.
module http_response_header_tokenizer #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  token_class,
    output logic        byte_valid,
    output logic [7:0]  out_byte,
    output logic        token_last,
    output logic        header_done,
    output logic        response_done,
    output logic [31:0] length_value
);

    localparam int WW    = LENGTH_BITS + 4;
    localparam int EXT_W = LENGTH_BITS + 32;

    // input stage
    logic       a_valid_reg;
    logic       a_opcode_reg;
    logic [7:0] a_byte_reg;

    // parse state
    hrht_pkg::phase_t       phase_reg, phase_next;
    logic                   hdr_reg, hdr_next;
    logic [3:0]             kpos_reg, kpos_next;
    logic                   kmis_reg, kmis_next;
    logic                   vlen_reg, vlen_next;
    logic                   vfirst_reg, vfirst_next;
    logic                   vdig_reg, vdig_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] cl_reg, cl_next;
    logic [LENGTH_BITS-1:0] bc_reg, bc_next;

    // output stage
    logic        out_valid_reg;
    logic [2:0]  cls_reg, cls_next;
    logic        bval_reg, bval_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        last_reg, last_next;
    logic        hdone_reg, hdone_next;
    logic        rdone_reg, rdone_next;
    logic [31:0] lval_reg, lval_next;

    logic             out_free;
    logic             a_fire;
    logic             in_take;
    logic [WW-1:0]    acc_w;
    logic [WW-1:0]    acc_sum;
    logic [EXT_W-1:0] cl_ext;

    assign out_free = !out_valid_reg || !out_stall;
    assign a_fire   = a_valid_reg && out_free;
    assign in_stall = a_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // acc*10 + digit, with headroom to detect saturation
    assign acc_w   = WW'(acc_reg);
    assign acc_sum = (acc_w << 3) + (acc_w << 1) + WW'(a_byte_reg[3:0]);

    always_comb
    begin
        logic [7:0] b;
        logic       done_n;
        b           = a_byte_reg;
        phase_next  = phase_reg;
        hdr_next    = hdr_reg;
        kpos_next   = kpos_reg;
        kmis_next   = kmis_reg;
        vlen_next   = vlen_reg;
        vfirst_next = vfirst_reg;
        vdig_next   = vdig_reg;
        acc_next    = acc_reg;
        cl_next     = cl_reg;
        bc_next     = bc_reg;
        cls_next    = hrht_pkg::CLS_NONE;
        bval_next   = 1'b0;
        last_next   = 1'b0;

        if (a_opcode_reg == hrht_pkg::OP_START)
        begin
            phase_next  = hrht_pkg::PH_PROTO;
            hdr_next    = 1'b1;
            kpos_next   = '0;
            kmis_next   = 1'b0;
            vlen_next   = 1'b0;
            vfirst_next = 1'b1;
            vdig_next   = 1'b1;
            acc_next    = '0;
            cl_next     = '0;
            bc_next     = '0;
        end
        else if (!(hdr_reg && b == hrht_pkg::CH_CR))
        begin
            case (phase_reg)
                hrht_pkg::PH_PROTO:
                begin
                    cls_next = hrht_pkg::CLS_PROTO;
                    if (b == hrht_pkg::CH_SPACE)
                    begin
                        last_next  = 1'b1;
                        phase_next = hrht_pkg::PH_STATUS;
                    end
                    else
                    begin
                        bval_next = 1'b1;
                    end
                end
                hrht_pkg::PH_STATUS:
                begin
                    cls_next = hrht_pkg::CLS_STATUS;
                    if (b == hrht_pkg::CH_SPACE)
                    begin
                        last_next  = 1'b1;
                        phase_next = hrht_pkg::PH_MSG;
                    end
                    else
                    begin
                        bval_next = 1'b1;
                    end
                end
                hrht_pkg::PH_MSG:
                begin
                    cls_next = hrht_pkg::CLS_MSG;
                    if (b == hrht_pkg::CH_LF)
                    begin
                        last_next  = 1'b1;
                        phase_next = hrht_pkg::PH_KEY;
                        kpos_next  = '0;
                        kmis_next  = 1'b0;
                    end
                    else
                    begin
                        bval_next = 1'b1;
                    end
                end
                hrht_pkg::PH_KEY:
                begin
                    if (b == hrht_pkg::CH_LF)
                    begin
                        // blank line ends the header
                        hdr_next   = 1'b0;
                        phase_next = (cl_reg != '0) ? hrht_pkg::PH_BODY
                                                    : hrht_pkg::PH_DONE;
                    end
                    else if (b == hrht_pkg::CH_COLON)
                    begin
                        cls_next    = hrht_pkg::CLS_KEY;
                        last_next   = 1'b1;
                        vlen_next   = !kmis_reg && kpos_reg == hrht_pkg::KEY_LEN;
                        vfirst_next = 1'b1;
                        vdig_next   = 1'b1;
                        acc_next    = '0;
                        phase_next  = hrht_pkg::PH_VAL;
                    end
                    else
                    begin
                        cls_next  = hrht_pkg::CLS_KEY;
                        bval_next = 1'b1;
                        if (!kmis_reg && kpos_reg < hrht_pkg::KEY_LEN &&
                            b == hrht_pkg::key_char(kpos_reg))
                        begin
                            kpos_next = kpos_reg + 4'd1;
                        end
                        else
                        begin
                            kmis_next = 1'b1;
                        end
                    end
                end
                hrht_pkg::PH_VAL:
                begin
                    cls_next = hrht_pkg::CLS_VAL;
                    if (b == hrht_pkg::CH_LF)
                    begin
                        last_next = 1'b1;
                        if (vlen_reg)
                        begin
                            cl_next = acc_reg;
                        end
                        phase_next = hrht_pkg::PH_KEY;
                        kpos_next  = '0;
                        kmis_next  = 1'b0;
                    end
                    else if (vfirst_reg)
                    begin
                        vfirst_next = 1'b0;
                    end
                    else
                    begin
                        bval_next = 1'b1;
                        if (vdig_reg)
                        begin
                            if (b inside {[hrht_pkg::CH_ZERO:hrht_pkg::CH_NINE]})
                            begin
                                if (acc_sum[WW-1:LENGTH_BITS] != '0)
                                begin
                                    acc_next = '1;
                                end
                                else
                                begin
                                    acc_next = acc_sum[LENGTH_BITS-1:0];
                                end
                            end
                            else
                            begin
                                vdig_next = 1'b0;
                            end
                        end
                    end
                end
                hrht_pkg::PH_BODY:
                begin
                    cls_next  = hrht_pkg::CLS_BODY;
                    bval_next = 1'b1;
                    if (bc_reg != '1)
                    begin
                        bc_next = bc_reg + LENGTH_BITS'(1);
                    end
                    if (cl_reg != '0 && bc_next >= cl_reg)
                    begin
                        last_next  = 1'b1;
                        phase_next = hrht_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    // finished: bytes are ignored
                end
            endcase
        end

        done_n = !(phase_next == hrht_pkg::PH_PROTO || phase_next == hrht_pkg::PH_STATUS ||
                   phase_next == hrht_pkg::PH_MSG   || phase_next == hrht_pkg::PH_KEY    ||
                   phase_next == hrht_pkg::PH_VAL   || phase_next == hrht_pkg::PH_BODY);
        obyte_next = bval_next ? b : 8'h00;
        hdone_next = !hdr_next;
        rdone_next = done_n;
    end

    assign cl_ext    = {32'd0, cl_next};
    assign lval_next = cl_ext[31:0];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= hrht_pkg::PH_PROTO;
            hdr_reg       <= 1'b1;
            kpos_reg      <= '0;
            kmis_reg      <= 1'b0;
            vlen_reg      <= 1'b0;
            vfirst_reg    <= 1'b1;
            vdig_reg      <= 1'b1;
            acc_reg       <= '0;
            cl_reg        <= '0;
            bc_reg        <= '0;
        end
        else
        begin
            if (in_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_fire)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (a_fire)
            begin
                phase_reg  <= phase_next;
                hdr_reg    <= hdr_next;
                kpos_reg   <= kpos_next;
                kmis_reg   <= kmis_next;
                vlen_reg   <= vlen_next;
                vfirst_reg <= vfirst_next;
                vdig_reg   <= vdig_next;
                acc_reg    <= acc_next;
                cl_reg     <= cl_next;
                bc_reg     <= bc_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_opcode_reg <= opcode;
            a_byte_reg   <= data_byte;
        end
        if (a_fire)
        begin
            cls_reg   <= cls_next;
            bval_reg  <= bval_next;
            obyte_reg <= obyte_next;
            last_reg  <= last_next;
            hdone_reg <= hdone_next;
            rdone_reg <= rdone_next;
            lval_reg  <= lval_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign token_class   = cls_reg;
    assign byte_valid    = bval_reg;
    assign out_byte      = obyte_reg;
    assign token_last    = last_reg;
    assign header_done   = hdone_reg;
    assign response_done = rdone_reg;
    assign length_value  = lval_reg;

    // header can only close into body or finished phase
    a_hdr_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !hdr_reg |-> (phase_reg == hrht_pkg::PH_BODY || phase_reg == hrht_pkg::PH_DONE))
        else $error("header closed outside body/done phase");

    a_done_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && response_done |-> header_done)
        else $error("response done before header done");

    a_valid_cls: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> token_class != hrht_pkg::CLS_NONE)
        else $error("valid byte without token class");

    a_start_clr: assert property (@(posedge clk) disable iff (!rst_n)
        a_fire && a_opcode_reg == hrht_pkg::OP_START |=>
            hdr_reg && kpos_reg == '0 && cl_reg == '0 && bc_reg == '0)
        else $error("start request did not clear parse state");

endmodule

### tb/sv/http_response_header_tokenizer_test.sv
// ----------------------------------------------------------------------------
// http_response_header_tokenizer_test
// Self-checking bench for the HTTP response tokenizer. A directed response
// covers the delimiters, dropped carriage returns, empty key and value, the
// blank line and bytes after done. Random responses follow: mostly
// well-formed, with Content-Length headers (near misses, empty, saturating),
// bodies of the announced length, plus broken ones. A predictor in the bench
// runs on each accepted request. Results are checked in order against it
// while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module http_response_header_tokenizer_test;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam logic [31:0] LEN_MAX     = 32'hFFFF_FFFF;
    localparam logic [8*14-1:0] LEN_KEY = "Content-Length";

    typedef struct packed {
        logic       op;
        logic [7:0] b;
        logic       hold;     // wait for all results before sending
        logic [5:0] gap;      // idle cycles after this request
    } byte_req_t;

    typedef struct packed {
        logic [2:0]  cls;
        logic        bv;
        logic [7:0]  ob;
        logic        last;
        logic        hdr;
        logic        done;
        logic [31:0] len;
    } tok_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = hrht_pkg::OP_START;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  token_class;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        token_last;
    logic        header_done;
    logic        response_done;
    logic [31:0] length_value;

    byte_req_t   rx_bytes[$];
    tok_result_t tokens_due[$];
    int unsigned total_reqs;
    int unsigned bytes_taken = 0;
    int unsigned tokens_seen = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    logic        gaps_on = 1'b1;
    logic        hold_next = 1'b0;
    logic [5:0]  gap_left = '0;
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;
    logic        calm = 1'b0;

    // predicted parser state
    hrht_pkg::phase_t ph;
    logic        hdr_open;
    logic [3:0]  key_pos;
    logic        key_bad;
    logic        val_is_len;
    logic        val_first;
    logic        val_digits;
    logic [31:0] val_acc;
    logic [31:0] clen;
    logic [31:0] body_cnt;

    http_response_header_tokenizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_class   (token_class),
        .byte_valid    (byte_valid),
        .out_byte      (out_byte),
        .token_last    (token_last),
        .header_done   (header_done),
        .response_done (response_done),
        .length_value  (length_value)
    );

    always #2 clk = ~clk;

    task automatic clear_parse();
        ph         = hrht_pkg::PH_PROTO;
        hdr_open   = 1'b1;
        key_pos    = '0;
        key_bad    = 1'b0;
        val_is_len = 1'b0;
        val_first  = 1'b1;
        val_digits = 1'b1;
        val_acc    = '0;
        clen       = '0;
        body_cnt   = '0;
    endtask

    task automatic tokenize_byte(input logic op, input logic [7:0] b);
        tok_result_t r;
        logic [31:0] d;
        r = '0;
        if (op == hrht_pkg::OP_START)
        begin
            clear_parse();
        end
        else
        begin
            if (!(hdr_open && b == hrht_pkg::CH_CR))
            begin
                case (ph)
                    hrht_pkg::PH_PROTO, hrht_pkg::PH_STATUS:
                    begin
                        r.cls = (ph == hrht_pkg::PH_PROTO) ? hrht_pkg::CLS_PROTO
                                                           : hrht_pkg::CLS_STATUS;
                        if (b == hrht_pkg::CH_SPACE)
                        begin
                            r.last = 1'b1;
                            if (ph == hrht_pkg::PH_PROTO)
                                ph = hrht_pkg::PH_STATUS;
                            else
                                ph = hrht_pkg::PH_MSG;
                        end
                        else
                            r.bv = 1'b1;
                    end
                    hrht_pkg::PH_MSG:
                    begin
                        r.cls = hrht_pkg::CLS_MSG;
                        if (b == hrht_pkg::CH_LF)
                        begin
                            r.last  = 1'b1;
                            ph      = hrht_pkg::PH_KEY;
                            key_pos = '0;
                            key_bad = 1'b0;
                        end
                        else
                            r.bv = 1'b1;
                    end
                    hrht_pkg::PH_KEY:
                    begin
                        if (b == hrht_pkg::CH_LF)
                        begin
                            // blank line closes the header
                            hdr_open = 1'b0;
                            if (clen != 0)
                                ph = hrht_pkg::PH_BODY;
                            else
                                ph = hrht_pkg::PH_DONE;
                        end
                        else if (b == hrht_pkg::CH_COLON)
                        begin
                            r.cls      = hrht_pkg::CLS_KEY;
                            r.last     = 1'b1;
                            val_is_len = !key_bad && key_pos == hrht_pkg::KEY_LEN;
                            val_first  = 1'b1;
                            val_digits = 1'b1;
                            val_acc    = '0;
                            ph         = hrht_pkg::PH_VAL;
                        end
                        else
                        begin
                            r.cls = hrht_pkg::CLS_KEY;
                            r.bv  = 1'b1;
                            if (!key_bad && key_pos < hrht_pkg::KEY_LEN &&
                                b == LEN_KEY[8 * (13 - int'(key_pos)) +: 8])
                                key_pos = key_pos + 1'b1;
                            else
                                key_bad = 1'b1;
                        end
                    end
                    hrht_pkg::PH_VAL:
                    begin
                        r.cls = hrht_pkg::CLS_VAL;
                        if (b == hrht_pkg::CH_LF)
                        begin
                            r.last = 1'b1;
                            if (val_is_len)
                                clen = val_acc;
                            ph      = hrht_pkg::PH_KEY;
                            key_pos = '0;
                            key_bad = 1'b0;
                        end
                        else if (val_first)
                            val_first = 1'b0;
                        else
                        begin
                            r.bv = 1'b1;
                            if (val_digits)
                            begin
                                if (b >= hrht_pkg::CH_ZERO && b <= hrht_pkg::CH_NINE)
                                begin
                                    d = 32'(b - hrht_pkg::CH_ZERO);
                                    if (val_acc > (LEN_MAX - d) / 32'd10)
                                        val_acc = LEN_MAX;
                                    else
                                        val_acc = val_acc * 32'd10 + d;
                                end
                                else
                                    val_digits = 1'b0;
                            end
                        end
                    end
                    hrht_pkg::PH_BODY:
                    begin
                        r.cls = hrht_pkg::CLS_BODY;
                        r.bv  = 1'b1;
                        if (body_cnt != LEN_MAX)
                            body_cnt = body_cnt + 32'd1;
                        if (clen != 0 && body_cnt >= clen)
                        begin
                            r.last = 1'b1;
                            ph     = hrht_pkg::PH_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            r.ob   = r.bv ? b : 8'h00;
            r.hdr  = !hdr_open;
            r.done = (ph == hrht_pkg::PH_DONE);
            r.len  = clen;
        end
        tokens_due.push_back(r);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] c);
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == a || v == c);
        return v;
    endfunction

    task automatic push_req(input logic op, input logic [7:0] b);
        byte_req_t q;
        q.op      = op;
        q.b       = b;
        q.hold    = hold_next;
        q.gap     = gaps_on ? 6'(pick_gap()) : 6'd0;
        hold_next = 1'b0;
        rx_bytes.push_back(q);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_req(hrht_pkg::OP_BYTE, s[i]);
    endtask

    task automatic push_response();
        int unsigned pick;
        int unsigned n;
        int          body_len;
        logic [7:0]  b;
        body_len = 0;
        gaps_on  = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 29) == 0)
            hold_next = 1'b1;
        push_req(hrht_pkg::OP_START, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
        begin
            // broken response, delimiters favored
            repeat ($urandom_range(1, 40))
            begin
                case ($urandom_range(0, 7))
                    0:       b = hrht_pkg::CH_CR;
                    1:       b = hrht_pkg::CH_LF;
                    2:       b = hrht_pkg::CH_COLON;
                    3:       b = hrht_pkg::CH_SPACE;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                push_req(hrht_pkg::OP_BYTE, b);
            end
            return;
        end
        if ($urandom_range(0, 3) != 0)
            push_text("HTTP/1.1");
        else
            repeat ($urandom_range(0, 5))
                push_req(hrht_pkg::OP_BYTE, any_but(hrht_pkg::CH_SPACE, hrht_pkg::CH_SPACE));
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_SPACE);
        repeat ($urandom_range(0, 3))
            push_req(hrht_pkg::OP_BYTE, any_but(hrht_pkg::CH_SPACE, hrht_pkg::CH_SPACE));
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_SPACE);
        repeat ($urandom_range(0, 6))
            push_req(hrht_pkg::OP_BYTE, any_but(hrht_pkg::CH_LF, hrht_pkg::CH_LF));
        if ($urandom_range(0, 1) != 0)
            push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_CR);
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_LF);

        repeat ($urandom_range(0, 4))
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3: push_text("Content-Length");
                4:          push_text("content-length");
                5:          push_text("Content-Lengthh");
                6:          push_text("Content-Len");
                7:          push_text("Content-Type");
                default:
                    repeat ($urandom_range(0, 8))
                        push_req(hrht_pkg::OP_BYTE,
                                 any_but(hrht_pkg::CH_COLON, hrht_pkg::CH_LF));
            endcase
            push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_COLON);
            if (pick <= 3)
            begin
                case ($urandom_range(0, 7))
                    0:  body_len = 0;   // empty value
                    1:
                    begin
                        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_SPACE);
                        case ($urandom_range(0, 2))
                            0:       push_text("4294967295");
                            1:       push_text("4294967296");
                            default: push_text("999999999999");
                        endcase
                        body_len = -1;
                    end
                    default:
                    begin
                        if ($urandom_range(0, 3) == 0)
                            push_req(hrht_pkg::OP_BYTE,
                                     any_but(hrht_pkg::CH_LF, hrht_pkg::CH_CR));
                        else
                            push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_SPACE);
                        n = $urandom_range(0, 24);
                        push_text($sformatf("%0d", n));
                        if ($urandom_range(0, 4) == 0)
                            push_text("x9");
                        body_len = int'(n);
                    end
                endcase
            end
            else
                repeat ($urandom_range(0, 6))
                    push_req(hrht_pkg::OP_BYTE, any_but(hrht_pkg::CH_LF, hrht_pkg::CH_LF));
            if ($urandom_range(0, 1) != 0)
                push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_CR);
            push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_LF);
        end

        if ($urandom_range(0, 1) != 0)
            push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_CR);
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_LF);
        if (body_len > 0)
            repeat (body_len)
                push_req(hrht_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        else if (body_len < 0)
            repeat ($urandom_range(3, 15))
                push_req(hrht_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        // bytes after the response finished are ignored
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2))
                push_req(hrht_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_reqs
        logic      taking;
        byte_req_t nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            opcode    <= hrht_pkg::OP_START;
            data_byte <= 8'h00;
            gap_left  <= '0;
        end
        else
        begin
            taking = in_valid && !in_stall;
            if (taking)
            begin
                tokenize_byte(opcode, data_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (!in_valid || taking)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1'b1;
                end
                else if (rx_bytes.size() != 0 &&
                         !(rx_bytes[0].hold && (taking || bytes_taken != tokens_seen)))
                begin
                    nxt = rx_bytes.pop_front();
                    in_valid  <= 1'b1;
                    opcode    <= nxt.op;
                    data_byte <= nxt.b;
                    gap_left  <= nxt.gap;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and result stall
    always @(posedge clk or negedge rst_n)
    begin : check_tokens
        tok_result_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            calm_left  <= 0;
            calm       <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                tokens_seen <= tokens_seen + 1;
                if (tokens_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected: class %0d, byte %0h",
                             $time, token_class, out_byte);
                    errors++;
                end
                else
                begin
                    want = tokens_due.pop_front();
                    check_field("token_class", 32'(want.cls), 32'(token_class));
                    check_field("byte_valid", 32'(want.bv), 32'(byte_valid));
                    check_field("out_byte", 32'(want.ob), 32'(out_byte));
                    check_field("token_last", 32'(want.last), 32'(token_last));
                    check_field("header_done", 32'(want.hdr), 32'(header_done));
                    check_field("response_done", 32'(want.done), 32'(response_done));
                    check_field("length_value", want.len, length_value);
                end
            end
            // alternate windows with and without stalls
            if (calm_left != 0)
                calm_left <= calm_left - 1;
            else
            begin
                calm_left <= $urandom_range(30, 200);
                calm      <= ($urandom_range(0, 3) == 0);
            end
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= pick_gap();
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        clear_parse();
        // directed response: delimiters, dropped CR, empty key and value,
        // skipped first value byte, blank line with no length, byte after done
        push_req(hrht_pkg::OP_START, 8'h00);
        push_req(hrht_pkg::OP_BYTE, "H");
        push_req(hrht_pkg::OP_BYTE, 8'hFF);
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_SPACE);
        push_req(hrht_pkg::OP_BYTE, 8'h00);
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_SPACE);
        push_req(hrht_pkg::OP_BYTE, "O");
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_CR);
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_LF);
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_COLON);
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_LF);
        push_text("C:x7z");
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_LF);
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_CR);
        push_req(hrht_pkg::OP_BYTE, hrht_pkg::CH_LF);
        push_req(hrht_pkg::OP_BYTE, 8'hFF);
        push_req(hrht_pkg::OP_START, 8'hFF);

        hold_next = 1'b1;
        while (rx_bytes.size() < 700)
            push_response();
        total_reqs = rx_bytes.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != total_reqs || tokens_seen != total_reqs)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && tokens_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
